### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### design/plss_pkg.sv
// ----------------------------------------------------------------------------
// plss_pkg
// types and codes shared by the pulse loop sound sequencer modules
// ----------------------------------------------------------------------------
package plss_pkg;

	// register indexes
	localparam logic [2:0] REG_START_WIDTHS = 3'd0;
	localparam logic [2:0] REG_WIDTH_DELTAS = 3'd1;
	localparam logic [2:0] REG_LEVELS       = 3'd2;
	localparam logic [2:0] REG_BUDGET       = 3'd3;
	localparam logic [2:0] REG_LOOP_COUNTS  = 3'd4;
	localparam logic [2:0] REG_PRE_DELAYS   = 3'd5;
	localparam logic [2:0] REG_POST_DELAYS  = 3'd6;
	localparam logic [2:0] REG_TIMING       = 3'd7;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// reset value of the timing register: base 0, one tick per width step
	localparam logic [31:0] TIMING_RESET = 32'h0001_0000;

	// sequencer phase codes
	localparam logic [2:0] PH_ENDED      = 3'd0;
	localparam logic [2:0] PH_OUTER_PRE  = 3'd1;
	localparam logic [2:0] PH_INNER_PRE  = 3'd2;
	localparam logic [2:0] PH_PULSE1     = 3'd3;
	localparam logic [2:0] PH_PULSE2     = 3'd4;
	localparam logic [2:0] PH_INNER_POST = 3'd5;
	localparam logic [2:0] PH_OUTER_POST = 3'd6;

	typedef struct packed {
		logic [15:0] start_widths;
		logic [31:0] width_deltas;
		logic [15:0] levels;
		logic [15:0] budget;
		logic [15:0] loop_counts;
		logic [31:0] pre_delays;
		logic [31:0] post_delays;
		logic [31:0] timing;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  outer_left;
		logic [7:0]  inner_left;
		logic [7:0]  first_start;
		logic [7:0]  second_start;
		logic [7:0]  first_width;
		logic [7:0]  second_width;
		logic [15:0] budget_left;
	} seq_state_t;

	typedef struct packed {
		logic [23:0] ticks;
		logic [7:0]  level;
		logic        final_seg;
		logic        over;
	} result_t;

endpackage

### design/pulse_loop_sound_sequencer_core.sv
// ----------------------------------------------------------------------------
// pulse_loop_sound_sequencer_core
// nested-loop two-pulse sound sequencer, one segment per request beat
// ----------------------------------------------------------------------------
// Each request beat yields one segment beat. A request is registered, then
// the step logic (a min, a 16x8 multiply-add and counter updates) updates
// the sequencer state and loads the result register, so a segment passes
// the request register and the result register, and one request is taken
// every cycle while the downstream side keeps up; the rate is set by the
// single state update per request. Output tdata holds ticks and level, tlast
// marks the last segment of the sequence, tuser marks "sequence over".
module pulse_loop_sound_sequencer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// request stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [0] restart
	// segment stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // [23:0] segment_ticks,
	                                                          // [31:24] segment_level
	output logic                               m_axis_tlast,  // final_segment
	output logic                               m_axis_tuser,  // [0] sequence_over
	// configuration write port
	input  logic                               cfg_we,
	input  logic [plss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	`include "assert_macros.svh"

	plss_pkg::cfg_t       cfg;
	plss_pkg::seq_state_t state_q;
	plss_pkg::seq_state_t state_nxt;
	plss_pkg::result_t    res_nxt;
	plss_pkg::result_t    res_s2;
	logic                 req_valid_s1;
	logic                 restart_s1;
	logic                 out_valid_s2;
	logic                 advance;

	plss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	plss_step u_step (
		.cfg     (cfg),
		.cur     (state_q),
		.restart (restart_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// the registered request moves on when the result slot is free or leaving
	assign advance       = req_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !req_valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			req_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			restart_s1 <= s_axis_tdata[0];
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= plss_pkg::PH_ENDED;
			state_q.outer_left   <= '0;
			state_q.inner_left   <= '0;
			state_q.first_start  <= '0;
			state_q.second_start <= '0;
			state_q.first_width  <= '0;
			state_q.second_width <= '0;
			state_q.budget_left  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {res_s2.level, res_s2.ticks};
	assign m_axis_tlast  = res_s2.final_seg;
	assign m_axis_tuser  = res_s2.over;

	// over marker carries zero fields and is never a final segment
	`ASSERT_IMPLIES(a_over_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata == 32'd0 && !m_axis_tlast)
	// a plain request after the end gives the over marker
	`ASSERT_NEXT(a_ended_over, clk, arst_n,
		advance && !restart_s1 && state_q.phase == plss_pkg::PH_ENDED,
		m_axis_tvalid && m_axis_tuser)
	// the final segment leaves the sequencer ended
	`ASSERT_NEXT(a_final_ends, clk, arst_n, advance && res_nxt.final_seg,
		state_q.phase == plss_pkg::PH_ENDED)
	// an empty result slot never blocks requests
	`ASSERT_IMPLIES(a_ready_free, clk, arst_n, !out_valid_s2, s_axis_tready)

endmodule

### design/plss_cfg_regs.sv
// ----------------------------------------------------------------------------
// plss_cfg_regs
// configuration register file, write only, one register per index
// ----------------------------------------------------------------------------
module plss_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [plss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output plss_pkg::cfg_t                     cfg
);

	plss_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_widths <= '0;
			cfg_q.width_deltas <= '0;
			cfg_q.levels       <= '0;
			cfg_q.budget       <= '0;
			cfg_q.loop_counts  <= '0;
			cfg_q.pre_delays   <= '0;
			cfg_q.post_delays  <= '0;
			cfg_q.timing       <= plss_pkg::TIMING_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				plss_pkg::REG_START_WIDTHS: cfg_q.start_widths <= cfg_wdata[15:0];
				plss_pkg::REG_WIDTH_DELTAS: cfg_q.width_deltas <= cfg_wdata;
				plss_pkg::REG_LEVELS:       cfg_q.levels       <= cfg_wdata[15:0];
				plss_pkg::REG_BUDGET:       cfg_q.budget       <= cfg_wdata[15:0];
				plss_pkg::REG_LOOP_COUNTS:  cfg_q.loop_counts  <= cfg_wdata[15:0];
				plss_pkg::REG_PRE_DELAYS:   cfg_q.pre_delays   <= cfg_wdata;
				plss_pkg::REG_POST_DELAYS:  cfg_q.post_delays  <= cfg_wdata;
				plss_pkg::REG_TIMING:       cfg_q.timing       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/plss_step.sv
// ----------------------------------------------------------------------------
// plss_step
// next-state and segment logic for one request of the sequencer
// ----------------------------------------------------------------------------
module plss_step (
	input  plss_pkg::cfg_t       cfg,
	input  plss_pkg::seq_state_t cur,
	input  logic                 restart,
	output plss_pkg::seq_state_t nxt,
	output plss_pkg::result_t    res
);

	plss_pkg::seq_state_t st;
	logic [7:0]  width_sel;
	logic [7:0]  steps;
	logic [15:0] budget_after;
	logic [23:0] pulse_len;

	always_comb begin
		// restart reloads outer count and start widths
		st = cur;
		if (restart) begin
			st.outer_left   = cfg.loop_counts[15:8];
			st.first_start  = cfg.start_widths[7:0];
			st.second_start = cfg.start_widths[15:8];
			st.phase = (cfg.loop_counts[15:8] != 8'd0) ? plss_pkg::PH_OUTER_PRE
				: plss_pkg::PH_ENDED;
		end

		// pulse length: base + scale * min(width, budget left)
		width_sel = (st.phase == plss_pkg::PH_PULSE1) ? st.first_width : st.second_width;
		// when budget is the smaller one it is below 256
		steps = ({8'd0, width_sel} < st.budget_left) ? width_sel : st.budget_left[7:0];
		budget_after = st.budget_left - {8'd0, steps};
		pulse_len = {8'd0, cfg.timing[15:0]} + 24'(cfg.timing[31:16]) * 24'(steps);

		nxt           = st;
		res.ticks     = '0;
		res.level     = cfg.levels[15:8];
		res.final_seg = 1'b0;
		res.over      = 1'b0;

		// phase sequencing
		case (st.phase)
			plss_pkg::PH_OUTER_PRE: begin
				nxt.first_width  = st.first_start;
				nxt.second_width = st.second_start;
				nxt.inner_left   = cfg.loop_counts[7:0];
				res.ticks        = {8'd0, cfg.pre_delays[15:0]};
				nxt.phase = (cfg.loop_counts[7:0] != 8'd0) ? plss_pkg::PH_INNER_PRE
					: plss_pkg::PH_OUTER_POST;
			end
			plss_pkg::PH_INNER_PRE: begin
				nxt.budget_left = cfg.budget;
				res.ticks       = {8'd0, cfg.pre_delays[31:16]};
				nxt.phase       = plss_pkg::PH_PULSE1;
			end
			plss_pkg::PH_PULSE1: begin
				nxt.budget_left = budget_after;
				res.ticks       = pulse_len;
				res.level       = cfg.levels[7:0];
				nxt.phase = (budget_after == 16'd0) ? plss_pkg::PH_INNER_POST
					: plss_pkg::PH_PULSE2;
			end
			plss_pkg::PH_PULSE2: begin
				nxt.budget_left = budget_after;
				res.ticks       = pulse_len;
				nxt.phase = (budget_after == 16'd0) ? plss_pkg::PH_INNER_POST
					: plss_pkg::PH_PULSE1;
			end
			plss_pkg::PH_INNER_POST: begin
				res.ticks        = {8'd0, cfg.post_delays[15:0]};
				nxt.first_width  = st.first_width + cfg.width_deltas[7:0];
				nxt.second_width = st.second_width + cfg.width_deltas[15:8];
				nxt.inner_left   = st.inner_left - 8'd1;
				nxt.phase = (st.inner_left != 8'd1) ? plss_pkg::PH_INNER_PRE
					: plss_pkg::PH_OUTER_POST;
			end
			plss_pkg::PH_OUTER_POST: begin
				res.ticks        = {8'd0, cfg.post_delays[31:16]};
				nxt.first_start  = st.first_start + cfg.width_deltas[23:16];
				nxt.second_start = st.second_start + cfg.width_deltas[31:24];
				nxt.outer_left   = st.outer_left - 8'd1;
				res.final_seg    = (st.outer_left == 8'd1);
				nxt.phase = (st.outer_left != 8'd1) ? plss_pkg::PH_OUTER_PRE
					: plss_pkg::PH_ENDED;
			end
			default: begin
				// nothing left: over marker with zero fields
				nxt.phase = plss_pkg::PH_ENDED;
				res.level = '0;
				res.over  = 1'b1;
			end
		endcase
	end

endmodule

### bench/pulse_loop_sound_sequencer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_loop_sound_sequencer_core_test
// Drives request beats into the sequencer and checks every segment beat.
// A local model of the loop state machine predicts each segment when its
// request is accepted. The checker compares the segment stream field by field
// against that prediction. Directed sequences cover the loop corner cases and
// the largest segments. Randomized register settings and request streams then
// run under several idle and stall mixes on both sides.
// ----------------------------------------------------------------------------
module pulse_loop_sound_sequencer_core_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // [0] restart
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // [23:0] segment_ticks, [31:24] segment_level
	logic        m_axis_tlast;       // final_segment
	logic        m_axis_tuser;       // [0] sequence_over
	logic                            cfg_we = 1'b0;
	logic [plss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [plss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	pulse_loop_sound_sequencer_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// register shadow and sequencer model state
	plss_pkg::cfg_t sound_regs;
	logic [2:0]  seq_phase;
	logic [7:0]  outer_count;
	logic [7:0]  inner_count;
	logic [7:0]  first_start_w;
	logic [7:0]  second_start_w;
	logic [7:0]  first_w;
	logic [7:0]  second_w;
	logic [15:0] budget_rem;

	plss_pkg::result_t expected_segments[$];
	plss_pkg::result_t want;
	int          mismatches = 0;
	int          send_gap_pct = 0;
	int          ready_stall_pct = 0;

	// pulse length from width and remaining budget, consumes budget
	function automatic logic [23:0] pulse_length(input logic [7:0] width);
		logic [15:0] steps;
		steps = (16'(width) < budget_rem) ? 16'(width) : budget_rem;
		budget_rem = budget_rem - steps;
		return 24'(sound_regs.timing[15:0]) + 24'(sound_regs.timing[31:16]) * 24'(steps);
	endfunction

	// next segment of the sound for one request
	function automatic plss_pkg::result_t next_segment(input logic restart);
		plss_pkg::result_t seg;
		seg = '0;
		seg.level = sound_regs.levels[15:8];
		if (restart) begin
			outer_count    = sound_regs.loop_counts[15:8];
			first_start_w  = sound_regs.start_widths[7:0];
			second_start_w = sound_regs.start_widths[15:8];
			seq_phase      = (outer_count != 0) ? plss_pkg::PH_OUTER_PRE : plss_pkg::PH_ENDED;
		end
		case (seq_phase)
			plss_pkg::PH_OUTER_PRE: begin
				first_w     = first_start_w;
				second_w    = second_start_w;
				inner_count = sound_regs.loop_counts[7:0];
				seg.ticks   = 24'(sound_regs.pre_delays[15:0]);
				seq_phase   = (inner_count != 0) ? plss_pkg::PH_INNER_PRE
					: plss_pkg::PH_OUTER_POST;
			end
			plss_pkg::PH_INNER_PRE: begin
				budget_rem = sound_regs.budget;
				seg.ticks  = 24'(sound_regs.pre_delays[31:16]);
				seq_phase  = plss_pkg::PH_PULSE1;
			end
			plss_pkg::PH_PULSE1: begin
				seg.ticks = pulse_length(first_w);
				seg.level = sound_regs.levels[7:0];
				seq_phase = (budget_rem == 0) ? plss_pkg::PH_INNER_POST : plss_pkg::PH_PULSE2;
			end
			plss_pkg::PH_PULSE2: begin
				seg.ticks = pulse_length(second_w);
				seq_phase = (budget_rem == 0) ? plss_pkg::PH_INNER_POST : plss_pkg::PH_PULSE1;
			end
			plss_pkg::PH_INNER_POST: begin
				seg.ticks   = 24'(sound_regs.post_delays[15:0]);
				first_w     = first_w + sound_regs.width_deltas[7:0];
				second_w    = second_w + sound_regs.width_deltas[15:8];
				inner_count = inner_count - 8'd1;
				seq_phase   = (inner_count != 0) ? plss_pkg::PH_INNER_PRE
					: plss_pkg::PH_OUTER_POST;
			end
			plss_pkg::PH_OUTER_POST: begin
				seg.ticks      = 24'(sound_regs.post_delays[31:16]);
				first_start_w  = first_start_w + sound_regs.width_deltas[23:16];
				second_start_w = second_start_w + sound_regs.width_deltas[31:24];
				outer_count    = outer_count - 8'd1;
				seg.final_seg  = (outer_count == 0);
				seq_phase      = (outer_count != 0) ? plss_pkg::PH_OUTER_PRE
					: plss_pkg::PH_ENDED;
			end
			default: begin
				seq_phase = plss_pkg::PH_ENDED;
				seg       = '0;
				seg.over  = 1'b1;
			end
		endcase
		return seg;
	endfunction

	// receiver side: random back-pressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);

	// segment checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_segments.size() == 0) begin
				$error("segment beat with no request pending");
				mismatches++;
			end else begin
				want = expected_segments.pop_front();
				if (m_axis_tdata[23:0] !== want.ticks) begin
					$error("segment_ticks: expected %0d, got %0d", want.ticks, m_axis_tdata[23:0]);
					mismatches++;
				end
				if (m_axis_tdata[31:24] !== want.level) begin
					$error("segment_level: expected %0d, got %0d", want.level,
						m_axis_tdata[31:24]);
					mismatches++;
				end
				if (m_axis_tlast !== want.final_seg) begin
					$error("final_segment: expected %0d, got %0d", want.final_seg, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser !== want.over) begin
					$error("sequence_over: expected %0d, got %0d", want.over, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	// one request beat, with optional gap and optional pause until drained
	task automatic send_request(input logic restart, output plss_pkg::result_t seg);
		if ($urandom_range(59) == 0) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while (expected_segments.size() != 0);
		end
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, restart};
		do @(posedge clk); while (!s_axis_tready);
		seg = next_segment(restart);
		expected_segments.push_back(seg);
	endtask

	// stop sending and wait out every pending segment plus pipeline slack
	task automatic drain_segments();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_segments.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [plss_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// write all registers, block must be idle
	task automatic load_config(input plss_pkg::cfg_t c);
		put_reg(plss_pkg::REG_START_WIDTHS, 32'(c.start_widths));
		put_reg(plss_pkg::REG_WIDTH_DELTAS, c.width_deltas);
		put_reg(plss_pkg::REG_LEVELS, 32'(c.levels));
		put_reg(plss_pkg::REG_BUDGET, 32'(c.budget));
		put_reg(plss_pkg::REG_LOOP_COUNTS, 32'(c.loop_counts));
		put_reg(plss_pkg::REG_PRE_DELAYS, c.pre_delays);
		put_reg(plss_pkg::REG_POST_DELAYS, c.post_delays);
		put_reg(plss_pkg::REG_TIMING, c.timing);
		cfg_we <= 1'b0;
		sound_regs = c;
	endtask

	// restart followed by plain requests until the sequence is over or cut short
	task automatic play_sequence(input int max_beats);
		plss_pkg::result_t seg;
		int n;
		n = 1;
		send_request(1'b1, seg);
		while (!seg.over && n < max_beats) begin
			send_request(1'b0, seg);
			n++;
		end
	endtask

	function automatic plss_pkg::cfg_t plain_config();
		plss_pkg::cfg_t c;
		c = '0;
		c.timing = plss_pkg::TIMING_RESET;
		return c;
	endfunction

	function automatic plss_pkg::cfg_t random_config();
		plss_pkg::cfg_t c;
		c.start_widths = ($urandom_range(1) != 0) ? 16'($urandom()) :
			{8'($urandom_range(0, 4)), 8'($urandom_range(0, 4))};
		c.width_deltas = $urandom();
		c.levels       = 16'($urandom());
		c.budget       = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 24));
		c.loop_counts  = ($urandom_range(9) == 0) ? 16'($urandom()) :
			{8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
		c.pre_delays   = $urandom();
		c.post_delays  = $urandom();
		c.timing       = $urandom();
		return c;
	endfunction

	// registers at reset value: no sequence to play
	task automatic test_reset_state();
		plss_pkg::result_t seg;
		send_request(1'b0, seg);
		send_request(1'b1, seg);
		drain_segments();
	endtask

	// zero inner count: outer delays only, then the over marker
	task automatic test_empty_loops();
		plss_pkg::cfg_t c;
		c = plain_config();
		c.loop_counts = 16'h0100;
		c.pre_delays  = 32'h0000_0011;
		c.post_delays = 32'h0022_0000;
		c.levels      = 16'hA55A;
		load_config(c);
		play_sequence(5);
		drain_segments();
	endtask

	// zero budget: one base-length pulse per inner iteration
	task automatic test_zero_budget();
		plss_pkg::cfg_t c;
		c = plain_config();
		c.loop_counts  = 16'h0101;
		c.start_widths = 16'h0705;
		c.timing       = 32'h0003_0009;
		c.pre_delays   = 32'h0002_0001;
		c.post_delays  = 32'h0004_0003;
		load_config(c);
		play_sequence(8);
		drain_segments();
	endtask

	// both widths zero with budget left: pulses alternate until restart
	task automatic test_endless_alternation();
		plss_pkg::cfg_t c;
		c = plain_config();
		c.loop_counts = 16'h0101;
		c.budget      = 16'd3;
		c.timing      = 32'h0005_0007;
		c.levels      = 16'h3CC3;
		load_config(c);
		play_sequence(6);
		drain_segments();
	endtask

	// every field at its top value: longest possible pulse segments
	task automatic test_largest_segments();
		plss_pkg::cfg_t c;
		c.start_widths = 16'hFFFF;
		c.width_deltas = 32'hFFFF_FFFF;
		c.levels       = 16'hFFFF;
		c.budget       = 16'hFFFF;
		c.loop_counts  = 16'hFFFF;
		c.pre_delays   = 32'hFFFF_FFFF;
		c.post_delays  = 32'hFFFF_FFFF;
		c.timing       = 32'hFFFF_FFFF;
		load_config(c);
		play_sequence(5);
		drain_segments();
	endtask

	// random settings per round, idle mix rotating over the rounds
	task automatic test_random_sequences();
		plss_pkg::result_t seg;
		for (int round = 0; round < 8; round++) begin
			case (round % 4)
				0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
				1: begin send_gap_pct = 62; ready_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  ready_stall_pct = 62; end
				default: begin send_gap_pct = 23; ready_stall_pct = 23; end
			endcase
			load_config(random_config());
			for (int k = 0; k < 80; k++)
				send_request(($urandom_range(29) == 0), seg);
			drain_segments();
		end
	endtask

	// timeout guard
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		sound_regs     = plain_config();
		seq_phase      = plss_pkg::PH_ENDED;
		outer_count    = '0;
		inner_count    = '0;
		first_start_w  = '0;
		second_start_w = '0;
		first_w        = '0;
		second_w       = '0;
		budget_rem     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_empty_loops();
		test_zero_budget();
		test_endless_alternation();
		test_largest_segments();
		test_random_sequences();

		drain_segments();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/plss_pkg.sv
design/plss_cfg_regs.sv
design/plss_step.sv
design/pulse_loop_sound_sequencer_core.sv
bench/pulse_loop_sound_sequencer_core_test.sv
